// ----- hdl/bser_pkg.sv -----
`timescale 1ns / 1ps

package bser_pkg;

   localparam int TABLE_DEPTH        = 16;
   localparam int DATA_WIDTH         = 32;
   localparam int INDEX_WIDTH        = $clog2(TABLE_DEPTH);
   localparam int LEN_WIDTH          = $clog2(TABLE_DEPTH + 1);
   localparam int CFG_LEN_WIDTH      = 5;
   localparam int ENTRY_INDEX_WIDTH  = 4;
   localparam int RESULT_INDEX_WIDTH = 4;
   localparam int PROBE_WIDTH        = 3;
   localparam int CSR_ADDR_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [CSR_ADDR_WIDTH-3:0] CSR_TABLE_LENGTH = '0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE_ADDR,
      S_PROBE_CMP,
      S_LEFT_ADDR,
      S_LEFT_CMP,
      S_RIGHT_ADDR,
      S_RIGHT_CMP,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

   typedef struct packed {
      logic                          found;
      logic [RESULT_INDEX_WIDTH-1:0] hit_index;
      logic [RESULT_INDEX_WIDTH-1:0] first_index;
      logic [RESULT_INDEX_WIDTH-1:0] last_index;
      logic [PROBE_WIDTH-1:0]        probe_count;
   } result_type;

endpackage

// ----- hdl/bser_ram.sv -----
`timescale 1ns / 1ps

module bser_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bser_cmp.sv -----
`timescale 1ns / 1ps

module bser_cmp (
   input  logic signed [bser_pkg::DATA_WIDTH-1:0] key,
   input  logic signed [bser_pkg::DATA_WIDTH-1:0] entry,
   output bser_pkg::cmp_type                      result
);

   always_comb begin
      result.eq = (key == entry);
      result.lt = (key < entry);
   end

endmodule

// ----- hdl/bser_ctrl.sv -----
`timescale 1ns / 1ps

module bser_ctrl (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic signed [bser_pkg::DATA_WIDTH-1:0]    start_key,
   input  logic [bser_pkg::CFG_LEN_WIDTH-1:0]        table_length,
   input  bser_pkg::cmp_type                         cmp,
   input  logic                                      slot_free,
   output logic signed [bser_pkg::DATA_WIDTH-1:0]    key,
   output logic [bser_pkg::INDEX_WIDTH-1:0]          rd_addr,
   output logic                                      ready,
   output logic                                      done,
   output bser_pkg::result_type                      result
);

   localparam int IW = bser_pkg::INDEX_WIDTH;
   localparam int LW = bser_pkg::LEN_WIDTH;
   localparam int PW = bser_pkg::PROBE_WIDTH;
   localparam int RW = bser_pkg::RESULT_INDEX_WIDTH;

   bser_pkg::ctrl_state_type state_ff, state_in;

   logic signed [bser_pkg::DATA_WIDTH-1:0] key_ff, key_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] lo_ff, lo_in;
   logic [LW-1:0] hi_ff, hi_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic [IW-1:0] first_ff, first_in;
   logic [IW-1:0] last_ff, last_in;
   logic [PW-1:0] probes_ff, probes_in;
   logic          hit_ff, hit_in;

   logic [LW-1:0] len_sat;
   logic [IW-1:0] mid_calc;
   logic [LW-1:0] lo_upd;
   logic [LW-1:0] hi_upd;
   logic          right_end;

   always_comb begin
      if (int'(table_length) > bser_pkg::TABLE_DEPTH) begin
         len_sat = LW'(bser_pkg::TABLE_DEPTH);
      end else begin
         len_sat = LW'(table_length);
      end
      mid_calc  = IW'(lo_ff + ((hi_ff - LW'(1) - lo_ff) >> 1));
      lo_upd    = cmp.lt ? lo_ff : LW'(mid_ff) + LW'(1);
      hi_upd    = cmp.lt ? LW'(mid_ff) : hi_ff;
      right_end = (LW'(last_ff) + LW'(1)) >= len_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bser_pkg::S_IDLE: begin
            if (start) begin
               state_in = (len_sat == '0) ? bser_pkg::S_DONE : bser_pkg::S_PROBE_ADDR;
            end
         end
         bser_pkg::S_PROBE_ADDR: begin
            state_in = bser_pkg::S_PROBE_CMP;
         end
         bser_pkg::S_PROBE_CMP: begin
            if (cmp.eq) begin
               state_in = bser_pkg::S_LEFT_ADDR;
            end else if (lo_upd < hi_upd) begin
               state_in = bser_pkg::S_PROBE_ADDR;
            end else begin
               state_in = bser_pkg::S_DONE;
            end
         end
         bser_pkg::S_LEFT_ADDR: begin
            state_in = (first_ff == '0) ? bser_pkg::S_RIGHT_ADDR : bser_pkg::S_LEFT_CMP;
         end
         bser_pkg::S_LEFT_CMP: begin
            state_in = cmp.eq ? bser_pkg::S_LEFT_ADDR : bser_pkg::S_RIGHT_ADDR;
         end
         bser_pkg::S_RIGHT_ADDR: begin
            state_in = right_end ? bser_pkg::S_DONE : bser_pkg::S_RIGHT_CMP;
         end
         bser_pkg::S_RIGHT_CMP: begin
            state_in = cmp.eq ? bser_pkg::S_RIGHT_ADDR : bser_pkg::S_DONE;
         end
         bser_pkg::S_DONE: begin
            if (slot_free) begin
               state_in = bser_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bser_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_addr = '0;
      ready   = 1'b0;
      done    = 1'b0;
      case (state_ff)
         bser_pkg::S_IDLE: begin
            ready = 1'b1;
         end
         bser_pkg::S_PROBE_ADDR: begin
            rd_addr = mid_calc;
         end
         bser_pkg::S_LEFT_ADDR: begin
            rd_addr = first_ff - IW'(1);
         end
         bser_pkg::S_RIGHT_ADDR: begin
            rd_addr = last_ff + IW'(1);
         end
         bser_pkg::S_DONE: begin
            done = slot_free;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_comb begin
      key_in    = key_ff;
      len_in    = len_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      probes_in = probes_ff;
      hit_in    = hit_ff;
      case (state_ff)
         bser_pkg::S_IDLE: begin
            if (start) begin
               key_in    = start_key;
               len_in    = len_sat;
               lo_in     = '0;
               hi_in     = len_sat;
               mid_in    = '0;
               first_in  = '0;
               last_in   = '0;
               probes_in = '0;
               hit_in    = 1'b0;
            end
         end
         bser_pkg::S_PROBE_ADDR: begin
            mid_in = mid_calc;
         end
         bser_pkg::S_PROBE_CMP: begin
            if (probes_ff != '1) begin
               probes_in = probes_ff + PW'(1);
            end
            if (cmp.eq) begin
               hit_in   = 1'b1;
               first_in = mid_ff;
               last_in  = mid_ff;
            end else begin
               lo_in = lo_upd;
               hi_in = hi_upd;
            end
         end
         bser_pkg::S_LEFT_CMP: begin
            if (cmp.eq) begin
               first_in = first_ff - IW'(1);
            end
         end
         bser_pkg::S_RIGHT_CMP: begin
            if (cmp.eq) begin
               last_in = last_ff + IW'(1);
            end
         end
         default: begin
            hit_in = hit_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bser_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff    <= key_in;
      len_ff    <= len_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      probes_ff <= probes_in;
      hit_ff    <= hit_in;
   end

   always_comb begin
      key                = key_ff;
      result.found       = hit_ff;
      result.hit_index   = hit_ff ? RW'(mid_ff) : '0;
      result.first_index = RW'(first_ff);
      result.last_index  = RW'(last_ff);
      result.probe_count = probes_ff;
   end

endmodule

// ----- hdl/binary_search_equal_range.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                         Payload
// req       in         req_valid / req_ready             operation, entry_index, data_value
// rsp       out        rsp_valid / rsp_ready             found, hit_index, first_index,
//                                                        last_index, probe_count
// csr       in/out     psel, penable, pwrite / pready    paddr, pwdata, prdata
//
// A table write gives no response, and the next request is taken at once.
// A search visits an address state and a compare state for each probe; a hit then adds the
// left and right scans, which stop at an unequal entry or at a table end. Each step waits on
// the single registered table read port.
// Reset clears the control state and table_length; the table itself is not cleared.
// A finished search waits in the done state while the response register holds a response that
// rsp_ready has not taken, and the block is not ready meanwhile.

module binary_search_equal_range (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic [bser_pkg::ENTRY_INDEX_WIDTH-1:0]  req_entry_index,
   input  logic signed [bser_pkg::DATA_WIDTH-1:0]  req_data_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_found,
   output logic [bser_pkg::RESULT_INDEX_WIDTH-1:0] rsp_hit_index,
   output logic [bser_pkg::RESULT_INDEX_WIDTH-1:0] rsp_first_index,
   output logic [bser_pkg::RESULT_INDEX_WIDTH-1:0] rsp_last_index,
   output logic [bser_pkg::PROBE_WIDTH-1:0]        rsp_probe_count,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [bser_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [bser_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [bser_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                    pready
);

   localparam int IW = bser_pkg::INDEX_WIDTH;
   localparam int CW = bser_pkg::CSR_ADDR_WIDTH;

   logic [bser_pkg::CFG_LEN_WIDTH-1:0] table_length_ff, table_length_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   bser_pkg::result_type               rsp_data_ff, rsp_data_in;

   logic                                   req_fire;
   logic                                   start;
   logic                                   wr_en;
   logic [IW-1:0]                          wr_addr;
   logic [IW-1:0]                          rd_addr;
   logic signed [bser_pkg::DATA_WIDTH-1:0] rd_data;
   logic signed [bser_pkg::DATA_WIDTH-1:0] key;
   bser_pkg::cmp_type                      cmp;
   bser_pkg::result_type                   result;
   logic                                   done;
   logic                                   slot_free;
   logic                                   csr_hit;

   assign req_fire  = req_valid && req_ready;
   assign start     = req_fire && (req_operation == bser_pkg::OP_SEARCH);
   assign wr_en     = req_fire && (req_operation == bser_pkg::OP_WRITE)
                      && (int'(req_entry_index) < bser_pkg::TABLE_DEPTH);
   assign wr_addr   = IW'(req_entry_index);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   bser_ram #(
      .WIDTH (bser_pkg::DATA_WIDTH),
      .DEPTH (bser_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bser_cmp u_cmp (
      .key    (key),
      .entry  (rd_data),
      .result (cmp)
   );

   bser_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .start_key    (req_data_value),
      .table_length (table_length_ff),
      .cmp          (cmp),
      .slot_free    (slot_free),
      .key          (key),
      .rd_addr      (rd_addr),
      .ready        (req_ready),
      .done         (done),
      .result       (result)
   );

   assign csr_hit = (paddr[CW-1:2] == bser_pkg::CSR_TABLE_LENGTH);
   assign pready  = 1'b1;

   always_comb begin
      table_length_in = table_length_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         table_length_in = pwdata[bser_pkg::CFG_LEN_WIDTH-1:0];
      end
      prdata = '0;
      if (csr_hit) begin
         prdata = bser_pkg::CSR_DATA_WIDTH'(table_length_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         table_length_ff <= table_length_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_data_ff.found;
   assign rsp_hit_index   = rsp_data_ff.hit_index;
   assign rsp_first_index = rsp_data_ff.first_index;
   assign rsp_last_index  = rsp_data_ff.last_index;
   assign rsp_probe_count = rsp_data_ff.probe_count;

endmodule

// ----- hdl/bser_checker.sv -----
`timescale 1ns / 1ps

module bser_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    req_operation,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic                                    rsp_found,
   input logic [bser_pkg::RESULT_INDEX_WIDTH-1:0] rsp_hit_index,
   input logic [bser_pkg::RESULT_INDEX_WIDTH-1:0] rsp_first_index,
   input logic [bser_pkg::RESULT_INDEX_WIDTH-1:0] rsp_last_index,
   input logic [bser_pkg::PROBE_WIDTH-1:0]        rsp_probe_count
);

   // A stalled response transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_hit_index) && $stable(rsp_first_index)
         && $stable(rsp_last_index) && $stable(rsp_probe_count))
      else $error("stalled response changed");

   // A miss reports all indices as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_hit_index == '0 && rsp_first_index == '0
         && rsp_last_index == '0)
      else $error("miss with nonzero index");

   // A hit lies inside its equal run and took at least one probe.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_first_index <= rsp_hit_index
         && rsp_hit_index <= rsp_last_index && rsp_probe_count != '0)
      else $error("hit outside its run");

   // A search transaction keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == bser_pkg::OP_SEARCH |=> !req_ready)
      else $error("ready right after a search");

endmodule

bind binary_search_equal_range bser_checker u_bser_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_found       (rsp_found),
   .rsp_hit_index   (rsp_hit_index),
   .rsp_first_index (rsp_first_index),
   .rsp_last_index  (rsp_last_index),
   .rsp_probe_count (rsp_probe_count)
);
